/* rtl/pss_pkg.sv */
// pss_pkg: shared types and constants for the preemptive priority scheduler
// request/result payload structs, per-cell control and the scan candidate
// no dependencies
package pss_pkg;

  localparam int MaxProcs = 16;

  localparam int ArrW  = 16;
  localparam int BurW  = 12;
  localparam int PriW  = 8;
  localparam int IdxW  = 6;
  localparam int TimeW = 17;

  typedef struct packed {
    logic [ArrW-1:0] arrive_tick;
    logic [BurW-1:0] work_ticks;
    logic [PriW-1:0] priority_level;
    logic            last_process;
  } pss_req_t;

  typedef struct packed {
    logic [IdxW-1:0]  process_index;
    logic [TimeW-1:0] finish_tick;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] wait_ticks;
    logic             last_result;
  } pss_res_t;

  // per-cell control from the top level
  typedef struct packed {
    logic load;
    logic pick;
  } pss_ctl_t;

  // best-so-far record and earliest pending arrival, passed down the chain
  typedef struct packed {
    logic            found;
    logic [PriW-1:0] prio;
    logic [IdxW-1:0] idx;
    logic [ArrW-1:0] arrival;
    logic [BurW-1:0] burst;
    logic [BurW-1:0] remain;
    logic            pend;
    logic [ArrW-1:0] next_arr;
  } pss_cand_t;

endpackage

/* rtl/preemptive_priority_scheduler.sv */
// preemptive_priority_scheduler: top level, load control, tick sequencer, results
// a chain of pss_cell slots scans for the next process once per tick
// depends on pss_pkg and pss_cell
//
//  channel   | signals                 | direction | flow
//  ----------+-------------------------+-----------+---------------------------
//  request   | start, busy, req_i      | in        | taken when start & !busy
//  result    | res_valid_o, res_o      | out       | one-cycle strobe, no stall
//
// a record that is not last is taken as soon as it is offered, back to back
// the last record (or the one that fills the table) starts a run: each simulated
// tick with work, and each idle gap, takes a full wave through the cell chain;
// busy falls with the last result
// reset clears the table's live bits, counters and the run flag
// results cannot be held off; res_valid_o is high for a single cycle per result
module preemptive_priority_scheduler #(
  parameter int MaxProcs = pss_pkg::MaxProcs
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pss_pkg::pss_req_t req_i,
  output logic              res_valid_o,
  output pss_pkg::pss_res_t res_o
);

  localparam int CntW  = $clog2(MaxProcs + 1);
  localparam int TickW = $clog2(2**16 + MaxProcs * 2**12 + 1);

  logic                run_q, run_d;
  logic [CntW-1:0]     scan_q, scan_d;
  logic [CntW-1:0]     loaded_q, loaded_d;
  logic [CntW-1:0]     fin_q, fin_d;
  logic [TickW-1:0]    tick_q, tick_d;
  logic                res_valid_q, res_valid_d;
  pss_pkg::pss_res_t   res_q, res_d;

  pss_pkg::pss_cand_t  cand [MaxProcs+1];
  pss_pkg::pss_ctl_t   ctl  [MaxProcs];
  logic [MaxProcs-1:0] pick_vec;

  logic                accept, decide, finish, last_load;
  logic [TickW-1:0]    tick_inc, turn, wait_t;
  pss_pkg::pss_cand_t  best;

  assign accept    = start && !run_q;
  assign last_load = req_i.last_process || (loaded_q == CntW'(MaxProcs - 1));
  assign best      = cand[MaxProcs];
  assign decide    = run_q && (scan_q == CntW'(MaxProcs));
  assign finish    = decide && best.found && (best.remain <= pss_pkg::BurW'(1));
  assign tick_inc  = tick_q + TickW'(1);
  assign turn      = tick_inc - TickW'(best.arrival);
  assign wait_t    = turn - TickW'(best.burst);

  assign cand[0] = '0;

  for (genvar i = 0; i < MaxProcs; i++) begin : g_cell
    assign pick_vec[i] = decide && best.found && (best.idx == pss_pkg::IdxW'(i));
    assign ctl[i].load = accept && (loaded_q == CntW'(i));
    assign ctl[i].pick = pick_vec[i];

    pss_cell #(
      .TickW (TickW),
      .Idx   (pss_pkg::IdxW'(i))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[i]),
      .rec_i  (req_i),
      .tick_i (tick_q),
      .cand_i (cand[i]),
      .cand_o (cand[i+1])
    );
  end

  always_comb begin
    run_d       = run_q;
    scan_d      = scan_q;
    loaded_d    = loaded_q;
    fin_d       = fin_q;
    tick_d      = tick_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (accept) begin
      loaded_d = loaded_q + CntW'(1);
      if (last_load) begin
        run_d  = 1'b1;
        scan_d = '0;
        tick_d = '0;
        fin_d  = '0;
      end
    end else if (run_q) begin
      if (!decide) begin
        scan_d = scan_q + CntW'(1);
      end else begin
        scan_d = '0;
        if (best.found) begin
          tick_d = tick_inc;
        end else begin
          // nothing eligible: jump to the earliest pending arrival
          tick_d = TickW'(best.next_arr);
        end
        if (finish) begin
          fin_d               = fin_q + CntW'(1);
          res_valid_d         = 1'b1;
          res_d.process_index = best.idx;
          res_d.finish_tick   = tick_inc[pss_pkg::TimeW-1:0];
          res_d.turnaround    = turn[pss_pkg::TimeW-1:0];
          res_d.wait_ticks    = wait_t[pss_pkg::TimeW-1:0];
          res_d.last_result   = (fin_d == loaded_q);
          if (fin_d == loaded_q) begin
            run_d    = 1'b0;
            loaded_d = '0;
            fin_d    = '0;
            tick_d   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      scan_q      <= '0;
      loaded_q    <= '0;
      fin_q       <= '0;
      tick_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      scan_q      <= scan_d;
      loaded_q    <= loaded_d;
      fin_q       <= fin_d;
      tick_q      <= tick_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = run_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // results only come out of a run
  a_res_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without a run");

  // the flagged result ends the run
  a_last_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_result) |-> !busy)
    else $error("run still busy after last result");

  // at most one cell is charged a tick
  a_one_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pick_vec))
    else $error("more than one cell picked");

  // counters are clear between runs
  a_idle_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> (fin_q == '0) && (tick_q == '0))
    else $error("run state not cleared while idle");

endmodule

/* rtl/pss_cell.sv */
// pss_cell: one process slot of the scheduler chain
// holds the record and merges it into the candidate from its upstream neighbor
// depends on pss_pkg
module pss_cell #(
  parameter int              TickW = 18,
  parameter logic [pss_pkg::IdxW-1:0] Idx = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pss_pkg::pss_ctl_t ctl_i,
  input  pss_pkg::pss_req_t rec_i,
  input  logic [TickW-1:0]  tick_i,
  input  pss_pkg::pss_cand_t cand_i,
  output pss_pkg::pss_cand_t cand_o
);

  logic                     live_q;
  logic [pss_pkg::ArrW-1:0] arr_q;
  logic [pss_pkg::BurW-1:0] burst_q;
  logic [pss_pkg::BurW-1:0] rem_q;
  logic [pss_pkg::PriW-1:0] prio_q;
  pss_pkg::pss_cand_t       cand_d, cand_q;
  logic                     elig, pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (ctl_i.load) begin
      live_q <= 1'b1;
    end else if (ctl_i.pick && (rem_q <= pss_pkg::BurW'(1))) begin
      live_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      arr_q   <= rec_i.arrive_tick;
      burst_q <= rec_i.work_ticks;
      rem_q   <= rec_i.work_ticks;
      prio_q  <= rec_i.priority_level;
    end else if (ctl_i.pick && (rem_q != '0)) begin
      rem_q <= rem_q - pss_pkg::BurW'(1);
    end
    cand_q <= cand_d;
  end

  assign elig    = live_q && (TickW'(arr_q) <= tick_i);
  assign pending = live_q && !elig;

  always_comb begin
    cand_d = cand_i;
    // strict compare keeps the lower index on a priority tie
    if (elig && (!cand_i.found || (prio_q > cand_i.prio))) begin
      cand_d.found   = 1'b1;
      cand_d.prio    = prio_q;
      cand_d.idx     = Idx;
      cand_d.arrival = arr_q;
      cand_d.burst   = burst_q;
      cand_d.remain  = rem_q;
    end
    if (pending && (!cand_i.pend || (arr_q < cand_i.next_arr))) begin
      cand_d.pend     = 1'b1;
      cand_d.next_arr = arr_q;
    end
  end

  assign cand_o = cand_q;

endmodule

/* bench/tb.sv */
// tb: self-checking bench for preemptive_priority_scheduler
// loads process tables, predicts every completion with a local scheduler model
// depends on pss_pkg and the scheduler rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NProcs      = pss_pkg::MaxProcs;
  localparam int ScanCycles  = NProcs + 1;
  localparam int CycleLimit  = 2_000_000;
  localparam int RandomItems = 330;

  // holds the loaded process table and the completions it must produce
  class completion_checker;
    logic [pss_pkg::ArrW-1:0] arrival [NProcs];
    logic [pss_pkg::BurW-1:0] burst   [NProcs];
    logic [pss_pkg::PriW-1:0] prio    [NProcs];
    int unsigned              loaded;
    pss_pkg::pss_res_t        expected_completions [$];
    int unsigned              errors;

    function void note_record(pss_pkg::pss_req_t r);
      arrival[loaded] = r.arrive_tick;
      burst[loaded]   = r.work_ticks;
      prio[loaded]    = r.priority_level;
      loaded++;
      if (r.last_process || loaded == NProcs) begin
        simulate_schedule();
        loaded = 0;
      end
    endfunction

    // one tick per pass; idle stretches jump to the next arrival
    function void simulate_schedule();
      int unsigned       tick;
      int unsigned       finished;
      int unsigned       next_arr;
      int unsigned       turn;
      int unsigned       remain [NProcs];
      bit                done   [NProcs];
      int                pick;
      pss_pkg::pss_res_t c;
      for (int i = 0; i < NProcs; i++) begin
        remain[i] = 32'(burst[i]);
        done[i]   = 1'b0;
      end
      tick     = 0;
      finished = 0;
      while (finished < loaded) begin
        pick     = -1;
        next_arr = 32'hFFFF_FFFF;
        for (int i = 0; i < loaded; i++) begin
          if (done[i]) continue;
          if (arrival[i] <= tick) begin
            // strict compare keeps the lowest index on a tie
            if (pick < 0 || prio[i] > prio[pick]) pick = i;
          end else if (arrival[i] < next_arr) begin
            next_arr = 32'(arrival[i]);
          end
        end
        if (pick < 0) begin
          tick = next_arr;
          continue;
        end
        if (remain[pick] != 0) remain[pick]--;
        tick++;
        if (remain[pick] == 0) begin
          done[pick] = 1'b1;
          finished++;
          turn = tick - 32'(arrival[pick]);
          c.process_index = pss_pkg::IdxW'(pick);
          c.finish_tick   = pss_pkg::TimeW'(tick);
          c.turnaround    = pss_pkg::TimeW'(turn);
          c.wait_ticks    = pss_pkg::TimeW'(turn - 32'(burst[pick]));
          c.last_result   = (finished == loaded);
          expected_completions.push_back(c);
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_completion(pss_pkg::pss_res_t got);
      pss_pkg::pss_res_t want;
      if (expected_completions.size() == 0) begin
        $error("unexpected completion for process %0d", got.process_index);
        errors++;
        return;
      end
      want = expected_completions.pop_front();
      compare_field("process_index", want.process_index, got.process_index);
      compare_field("finish_tick", want.finish_tick, got.finish_tick);
      compare_field("turnaround", want.turnaround, got.turnaround);
      compare_field("wait_ticks", want.wait_ticks, got.wait_ticks);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  pss_pkg::pss_req_t req_i;
  logic              res_valid_o;
  pss_pkg::pss_res_t res_o;

  completion_checker completions = new();

  preemptive_priority_scheduler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) completions.check_completion(res_o);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[preemptive_priority_scheduler] ERROR");
    $finish;
  end

  function automatic pss_pkg::pss_req_t make_record(int unsigned arr, int unsigned bur,
                                                    int unsigned pri, bit last);
    pss_pkg::pss_req_t r;
    r.arrive_tick    = pss_pkg::ArrW'(arr);
    r.work_ticks     = pss_pkg::BurW'(bur);
    r.priority_level = pss_pkg::PriW'(pri);
    r.last_process   = last;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(3, 1);
    return $urandom_range(60, 8);
  endfunction

  // holds start until the request is taken at an edge with busy low
  task automatic issue_record(input pss_pkg::pss_req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    completions.note_record(r);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    logic [63:0] junk;
    if (cycles != 0) begin
      junk = {$urandom, $urandom};
      start <= 1'b0;
      req_i <= junk[$bits(pss_pkg::pss_req_t)-1:0];
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (completions.expected_completions.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    pss_pkg::pss_req_t r;
    int unsigned       sent;
    int unsigned       n;
    int unsigned       big_left;
    int unsigned       arr_mode;
    bit                quiet;
    bit                narrow;

    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-process runs at both extremes
    issue_record(make_record(0, 1, 0, 1'b1));
    pause_sender(sender_gap());
    issue_record(make_record(16'hFFFF, 12'hFFF, 8'hFF, 1'b1));
    // tie on priority, preemption, then an idle stretch before a late arrival
    issue_record(make_record(10, 3, 5, 1'b0));
    issue_record(make_record(10, 2, 5, 1'b0));
    pause_sender(2);
    issue_record(make_record(11, 2, 200, 1'b0));
    issue_record(make_record(500, 1, 0, 1'b1));
    // table fills with no last marker
    for (int i = 0; i < NProcs; i++) begin
      issue_record(make_record(i * 3, 2 + (i % 3), (i * 37) % 256, 1'b0));
    end
    wait_drained();

    big_left = 3;
    sent     = 0;
    while (sent < RandomItems) begin
      n        = ($urandom_range(4) == 0) ? NProcs : $urandom_range(6, 1);
      arr_mode = $urandom_range(2);
      narrow   = ($urandom_range(1) == 1);
      quiet    = ($urandom_range(3) == 0);
      for (int k = 0; k < n; k++) begin
        case (arr_mode)
          0: r.arrive_tick = pss_pkg::ArrW'($urandom_range(20));
          1: r.arrive_tick = pss_pkg::ArrW'($urandom_range(2000));
          default: r.arrive_tick = pss_pkg::ArrW'($urandom_range(65535));
        endcase
        // long bursts are rare since every tick costs a full scan
        if (big_left != 0 && $urandom_range(99) == 0) begin
          r.work_ticks = pss_pkg::BurW'($urandom_range(4095, 1));
          big_left--;
        end else begin
          r.work_ticks = pss_pkg::BurW'($urandom_range(24, 1));
        end
        r.priority_level = narrow ? pss_pkg::PriW'($urandom_range(3))
                                  : pss_pkg::PriW'($urandom_range(255));
        r.last_process   = (k == n - 1) && (n < NProcs || $urandom_range(1) == 1);
        if (!quiet) pause_sender(sender_gap());
        issue_record(r);
        sent++;
      end
      if ($urandom_range(5) == 0) wait_drained();
    end

    wait_drained();
    repeat (4 * ScanCycles) @(posedge clk_i);
    if (completions.errors == 0) begin
      $display("[preemptive_priority_scheduler] OK");
    end else begin
      $display("[preemptive_priority_scheduler] ERROR");
    end
    $finish;
  end

endmodule

/* preemptive_priority_scheduler.f */
rtl/pss_pkg.sv
rtl/pss_cell.sv
rtl/preemptive_priority_scheduler.sv
bench/tb.sv
